// ===== rtl/ipk_pkg.sv =====
// ----------------------------------------------------------------------------
// ipk_pkg
// Shared types and constants for the iambic paddle keyer.
// ----------------------------------------------------------------------------
`default_nettype none

package ipk_pkg;

  localparam int DIT_W            = 11;
  localparam int THR_W            = 14;
  localparam int LEN_W            = 3;
  localparam int PAT_W            = 7;
  localparam int MAX_ELEMENTS_DEF = 7;
  localparam int TIMER_BITS_DEF   = 16;

  localparam logic [DIT_W-1:0] DIT_LENGTH_RESET = 11'd60;

  typedef enum logic [2:0] {
    PH_SPACE   = 3'd0,
    PH_DIT     = 3'd1,
    PH_DIT_GAP = 3'd2,
    PH_DAH     = 3'd3,
    PH_DAH_GAP = 3'd4
  } phase_e;

  typedef struct packed {
    logic [THR_W-1:0] one_dit;
    logic [THR_W-1:0] two_dit;
    logic [THR_W-1:0] three_dit;
    logic [THR_W-1:0] six_dit;
  } thr_t;

  typedef struct packed {
    logic             key_down;
    logic             char_done;
    logic [LEN_W-1:0] char_length;
    logic [PAT_W-1:0] char_pattern;
    logic             word_done;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ipk_cfg.sv =====
// ----------------------------------------------------------------------------
// ipk_cfg
// Dit length register and the timing limits derived from it.
// ----------------------------------------------------------------------------
`default_nettype none

module ipk_cfg
  import ipk_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [DIT_W-1:0] wr_data_i,
  output thr_t                  thr_o
);

  logic [DIT_W-1:0] dit_len_q;
  logic [THR_W-1:0] dit_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dit_len_q <= DIT_LENGTH_RESET;
    end else if (wr_en_i) begin
      dit_len_q <= wr_data_i;
    end
  end

  assign dit_ext = THR_W'(dit_len_q);

  always_comb begin
    thr_o.one_dit   = dit_ext;
    thr_o.two_dit   = dit_ext << 1;
    thr_o.three_dit = (dit_ext << 1) + dit_ext;
    thr_o.six_dit   = (dit_ext << 2) + (dit_ext << 1);
  end

endmodule

`default_nettype wire

// ===== rtl/ipk_fsm.sv =====
// ----------------------------------------------------------------------------
// ipk_fsm
// Keyer state machine with paddle latches, elapsed timer and element recorder.
// ----------------------------------------------------------------------------
`default_nettype none

module ipk_fsm
  import ipk_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic dit_i,
  input  wire logic dah_i,
  input  wire thr_t thr_i,
  output result_t   res_o
);

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W = (TIMER_BITS > THR_W) ? TIMER_BITS : THR_W;

  phase_e                  phase_q, phase_d;
  logic                    dit_mem_q, dit_mem_d;
  logic                    dah_mem_q, dah_mem_d;
  logic                    in_char_q, in_char_d;
  logic                    in_word_q, in_word_d;
  logic [TIMER_BITS-1:0]   ticks_q, ticks_d;
  logic [MAX_ELEMENTS-1:0] bits_q, bits_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic                    key_q, key_d;

  logic [TIMER_BITS-1:0]   ticks_inc;
  logic [CMP_W-1:0]        ticks_ext;
  logic                    gt_one, gt_two, gt_three, gt_six;
  logic                    start, start_dah;
  logic [CNT_W+LEN_W-1:0]  len_wide;
  logic [MAX_ELEMENTS+PAT_W-1:0] pat_wide;

  assign ticks_inc = (ticks_q == {TIMER_BITS{1'b1}}) ? ticks_q
                                                     : ticks_q + TIMER_BITS'(1);
  assign ticks_ext = CMP_W'(ticks_inc);
  assign gt_one    = ticks_ext > CMP_W'(thr_i.one_dit);
  assign gt_two    = ticks_ext > CMP_W'(thr_i.two_dit);
  assign gt_three  = ticks_ext > CMP_W'(thr_i.three_dit);
  assign gt_six    = ticks_ext > CMP_W'(thr_i.six_dit);

  assign len_wide  = {{LEN_W{1'b0}}, count_q};
  assign pat_wide  = {{PAT_W{1'b0}}, bits_q};

  always_comb begin
    phase_d   = phase_q;
    dit_mem_d = dit_mem_q | dit_i;
    dah_mem_d = dah_mem_q | dah_i;
    in_char_d = in_char_q;
    in_word_d = in_word_q;
    ticks_d   = ticks_inc;
    bits_d    = bits_q;
    count_d   = count_q;
    key_d     = key_q;
    start     = 1'b0;
    start_dah = 1'b0;
    res_o     = '0;

    case (phase_q)
      PH_SPACE: begin
        if (dit_mem_d) begin
          start = 1'b1;
        end else if (dah_mem_d) begin
          start     = 1'b1;
          start_dah = 1'b1;
        end else if (in_char_q && gt_two) begin
          in_char_d         = 1'b0;
          res_o.char_done    = 1'b1;
          res_o.char_length  = len_wide[LEN_W-1:0];
          res_o.char_pattern = pat_wide[PAT_W-1:0];
          count_d           = '0;
          bits_d            = '0;
        end else if (in_word_q && gt_six) begin
          in_word_d       = 1'b0;
          res_o.word_done = 1'b1;
        end
      end
      PH_DIT: begin
        if (gt_one) begin
          key_d     = 1'b0;
          dit_mem_d = 1'b0;
          ticks_d   = '0;
          phase_d   = PH_DIT_GAP;
        end
      end
      PH_DIT_GAP: begin
        if (gt_one) begin
          if (dah_mem_d) begin
            start     = 1'b1;
            start_dah = 1'b1;
          end else if (dit_mem_d) begin
            start = 1'b1;
          end else begin
            phase_d = PH_SPACE;
          end
        end
      end
      PH_DAH: begin
        if (gt_three) begin
          key_d     = 1'b0;
          dah_mem_d = 1'b0;
          ticks_d   = '0;
          phase_d   = PH_DAH_GAP;
        end
      end
      PH_DAH_GAP: begin
        if (gt_one) begin
          if (dit_mem_d) begin
            start = 1'b1;
          end else if (dah_mem_d) begin
            start     = 1'b1;
            start_dah = 1'b1;
          end else begin
            phase_d = PH_SPACE;
          end
        end
      end
      default: begin
        phase_d = PH_SPACE;
      end
    endcase

    if (start) begin
      dit_mem_d = 1'b0;
      dah_mem_d = 1'b0;
      in_char_d = 1'b1;
      in_word_d = 1'b1;
      if (count_q < CNT_W'(MAX_ELEMENTS)) begin
        for (int i = 0; i < MAX_ELEMENTS; i++) begin
          if (start_dah && (count_q == CNT_W'(i))) begin
            bits_d[i] = 1'b1;
          end
        end
        count_d = count_q + CNT_W'(1);
      end
      key_d   = 1'b1;
      ticks_d = '0;
      phase_d = start_dah ? PH_DAH : PH_DIT;
    end

    res_o.key_down = key_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SPACE;
      dit_mem_q <= 1'b0;
      dah_mem_q <= 1'b0;
      in_char_q <= 1'b0;
      in_word_q <= 1'b0;
      ticks_q   <= '0;
      bits_q    <= '0;
      count_q   <= '0;
      key_q     <= 1'b0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      dit_mem_q <= dit_mem_d;
      dah_mem_q <= dah_mem_d;
      in_char_q <= in_char_d;
      in_word_q <= in_word_d;
      ticks_q   <= ticks_d;
      bits_q    <= bits_d;
      count_q   <= count_d;
      key_q     <= key_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/iambic_paddle_keyer_core.sv =====
// ----------------------------------------------------------------------------
// iambic_paddle_keyer_core
// Iambic paddle keyer: one request per tick in, one keyer result per tick out.
// ----------------------------------------------------------------------------
// Throughput is one request per cycle, limited only by the output stall.
// The paddle levels pass an input register, the keyer step and a result register.
// Reset clears all keyer state and sets the dit length to 60 ticks.
`default_nettype none

module iambic_paddle_keyer_core
  import ipk_pkg::*;
#(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF,
  parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [DIT_W-1:0] cfg_data_i,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire logic             dit_pressed_i,
  input  wire logic             dah_pressed_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output logic                  key_down_o,
  output logic                  char_done_o,
  output logic [LEN_W-1:0]      char_length_o,
  output logic [PAT_W-1:0]      char_pattern_o,
  output logic                  word_done_o
);

  thr_t    thr;
  result_t res;
  result_t res_q;
  logic    s1_valid_q, s1_valid_d;
  logic    s1_dit_q, s1_dah_q;
  logic    out_valid_q, out_valid_d;
  logic    advance, step, accept;

  assign cfg_ready_o = 1'b1;

  ipk_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i && cfg_ready_o),
    .wr_data_i (cfg_data_i),
    .thr_o     (thr)
  );

  ipk_fsm #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .TIMER_BITS   (TIMER_BITS)
  ) u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .dit_i  (s1_dit_q),
    .dah_i  (s1_dah_q),
    .thr_i  (thr),
    .res_o  (res)
  );

  assign advance    = !out_valid_q || !out_stall_i;
  assign step       = s1_valid_q && advance;
  assign in_stall_o = s1_valid_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (advance) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = advance ? s1_valid_q : out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_dit_q <= dit_pressed_i;
      s1_dah_q <= dah_pressed_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign key_down_o     = res_q.key_down;
  assign char_done_o    = res_q.char_done;
  assign char_length_o  = res_q.char_length;
  assign char_pattern_o = res_q.char_pattern;
  assign word_done_o    = res_q.word_done;

`ifndef SYNTH
  a_char_unkeyed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_done_o |-> !key_down_o && !word_done_o)
    else $error("Character end reported while keyed or with a word end.");

  a_hold_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && out_stall_i |=> s1_valid_q && out_valid_q)
    else $error("Pending request lost while the output was stalled.");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q)
    else $error("Input stalled with room in the pipeline.");
`endif

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the iambic paddle keyer core. Every accepted tick
// request is run through a keyer model in the bench and the result it
// predicts is queued. Each result the core delivers is compared field by field
// with the oldest queued one. Directed sequences and random paddle bursts at
// several dit lengths run, mostly with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
  import ipk_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          IDLE_PCT     = 14;
  localparam int          DRAIN_CYCLES = 8;
  localparam int          STALL_LIMIT  = 2000;
  localparam int unsigned TIMER_MAX    = (1 << TIMER_BITS_DEF) - 1;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_valid_i;
  logic             cfg_ready_o;
  logic [DIT_W-1:0] cfg_data_i;
  logic             in_valid_i;
  logic             in_stall_o;
  logic             dit_pressed_i;
  logic             dah_pressed_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic             key_down_o;
  logic             char_done_o;
  logic [LEN_W-1:0] char_length_o;
  logic [PAT_W-1:0] char_pattern_o;
  logic             word_done_o;

  iambic_paddle_keyer_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .dit_pressed_i  (dit_pressed_i),
    .dah_pressed_i  (dah_pressed_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .key_down_o     (key_down_o),
    .char_done_o    (char_done_o),
    .char_length_o  (char_length_o),
    .char_pattern_o (char_pattern_o),
    .word_done_o    (word_done_o)
  );

  result_t          due_results[$];
  int               error_count   = 0;
  bit               steady        = 1'b0;
  int               hold_off_left = 0;

  logic [DIT_W-1:0] dit_len   = DIT_LENGTH_RESET;
  phase_e           phase     = PH_SPACE;
  logic             dit_mem   = 1'b0;
  logic             dah_mem   = 1'b0;
  logic             in_char   = 1'b0;
  logic             in_word   = 1'b0;
  int unsigned      since_mark = 0;
  logic [PAT_W-1:0] elem_bits = '0;
  int unsigned      elem_cnt  = 0;
  logic             key_lvl   = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void start_element(input bit is_dah);
    dit_mem = 1'b0;
    dah_mem = 1'b0;
    in_char = 1'b1;
    in_word = 1'b1;
    if (elem_cnt < MAX_ELEMENTS_DEF) begin
      if (is_dah) begin
        elem_bits[elem_cnt] = 1'b1;
      end
      elem_cnt++;
    end
    key_lvl    = 1'b1;
    since_mark = 0;
    phase      = is_dah ? PH_DAH : PH_DIT;
  endfunction

  function automatic result_t advance_keyer(input logic dit, input logic dah);
    result_t     r;
    int unsigned d;
    r = '0;
    d = 32'(dit_len);
    if (since_mark < TIMER_MAX) since_mark++;
    if (dit) dit_mem = 1'b1;
    if (dah) dah_mem = 1'b1;
    case (phase)
      PH_SPACE: begin
        if (dit_mem) begin
          start_element(1'b0);
        end else if (dah_mem) begin
          start_element(1'b1);
        end else if (in_char && since_mark > 2 * d) begin
          in_char        = 1'b0;
          r.char_done    = 1'b1;
          r.char_length  = LEN_W'(elem_cnt);
          r.char_pattern = elem_bits;
          elem_cnt       = 0;
          elem_bits      = '0;
        end else if (in_word && since_mark > 6 * d) begin
          in_word     = 1'b0;
          r.word_done = 1'b1;
        end
      end
      PH_DIT: begin
        if (since_mark > d) begin
          key_lvl    = 1'b0;
          dit_mem    = 1'b0;
          since_mark = 0;
          phase      = PH_DIT_GAP;
        end
      end
      PH_DIT_GAP: begin
        if (since_mark > d) begin
          if (dah_mem) start_element(1'b1);
          else if (dit_mem) start_element(1'b0);
          else phase = PH_SPACE;
        end
      end
      PH_DAH: begin
        if (since_mark > 3 * d) begin
          key_lvl    = 1'b0;
          dah_mem    = 1'b0;
          since_mark = 0;
          phase      = PH_DAH_GAP;
        end
      end
      PH_DAH_GAP: begin
        if (since_mark > d) begin
          if (dit_mem) start_element(1'b0);
          else if (dah_mem) start_element(1'b1);
          else phase = PH_SPACE;
        end
      end
      default: begin
        phase = PH_SPACE;
      end
    endcase
    r.key_down = key_lvl;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_results.size() == 0) begin
        $error("result delivered with no request outstanding");
        error_count++;
      end else begin
        want = due_results.pop_front();
        check_field("key_down", 8'(want.key_down), 8'(key_down_o));
        check_field("char_done", 8'(want.char_done), 8'(char_done_o));
        check_field("char_length", 8'(want.char_length), 8'(char_length_o));
        check_field("char_pattern", 8'(want.char_pattern), 8'(char_pattern_o));
        check_field("word_done", 8'(want.word_done), 8'(word_done_o));
      end
    end
  end

  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_left > 0) begin
        out_stall_i <= 1'b1;
        hold_off_left--;
      end else begin
        out_stall_i <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_tick(input logic dit, input logic dah);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    dit_pressed_i <= dit;
    dah_pressed_i <= dah;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    due_results.push_back(advance_keyer(dit, dah));
    @(negedge clk_i);
  endtask

  task automatic send_run(input logic dit, input logic dah, input int count);
    repeat (count) send_tick(dit, dah);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (due_results.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_dit_length(input logic [DIT_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    dit_len = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_default_dit_length();
    send_run(1'b1, 1'b0, 1);
    send_run(1'b0, 1'b0, 190);
  endtask

  task automatic test_single_elements();
    write_dit_length(DIT_W'(1));
    send_run(1'b1, 1'b0, 1);
    send_run(1'b0, 1'b0, 9);
    send_run(1'b0, 1'b1, 1);
    send_run(1'b0, 1'b0, 11);
    send_run(1'b1, 1'b1, 1);
    send_run(1'b0, 1'b0, 3);
    send_run(1'b1, 1'b0, 3);
    send_run(1'b0, 1'b1, 5);
    send_run(1'b0, 1'b0, 12);
  endtask

  task automatic test_zero_dit_squeeze();
    write_dit_length(DIT_W'(0));
    send_run(1'b1, 1'b1, 20);
    send_run(1'b0, 1'b0, 4);
  endtask

  task automatic test_output_hold_off();
    write_dit_length(DIT_W'(2));
    hold_off_left = 80;
    repeat (30) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_sender_pause();
    repeat (20) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    wait_drained();
    repeat (20) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_random_keying(input logic [DIT_W-1:0] d, input int n_ticks,
                                    input bit no_idle);
    int   sent;
    int   len;
    int   kind;
    int   span;
    logic lv_dit;
    logic lv_dah;
    write_dit_length(d);
    steady = no_idle;
    span   = (d == 0) ? 1 : int'(d);
    sent   = 0;
    while (sent < n_ticks) begin
      kind = $urandom_range(0, 9);
      lv_dit = (kind < 3) || (kind == 5) || (kind == 6);
      lv_dah = (kind >= 3) && (kind < 7);
      if (kind < 3) len = $urandom_range(1, 2 * span + 2);
      else if (kind < 7) len = $urandom_range(1, 4 * span + 2);
      else if (kind < 9) len = $urandom_range(1, 8 * span + 2);
      else len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if (kind == 9) begin
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          send_tick(lv_dit, lv_dah);
        end
      end
      sent += len;
    end
    steady = 1'b0;
  endtask

  task automatic test_longest_dit_length();
    write_dit_length({DIT_W{1'b1}});
    steady = 1'b1;
    send_run(1'b1, 1'b0, 1);
    send_run(1'b0, 1'b0, 20);
    steady = 1'b0;
  endtask

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    dit_pressed_i = 1'b0;
    dah_pressed_i = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_default_dit_length();
    test_single_elements();
    test_zero_dit_squeeze();
    test_output_hold_off();
    test_sender_pause();
    test_random_keying(DIT_W'(1), 40, 1'b0);
    test_random_keying(DIT_W'(2), 40, 1'b1);
    test_random_keying(DIT_W'(3), 30, 1'b0);
    test_random_keying(DIT_W'(0), 30, 1'b0);
    test_random_keying(DIT_W'($urandom_range(4, 12)), 30, 1'b0);
    test_longest_dit_length();
    test_random_keying(DIT_W'(1), 20, 1'b0);
    wait_drained();
    if (error_count == 0 && due_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
